// ----- hw/rtl/bouncing_ball_integrator_unit_defines.svh -----
// Assertion macros shared by the bouncing ball integrator RTL.
`ifndef BOUNCING_BALL_INTEGRATOR_UNIT_DEFINES_SVH
`define BOUNCING_BALL_INTEGRATOR_UNIT_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define BBI_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define BBI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bbi_pkg.sv -----
// Types, register indexes and constants of the bouncing ball integrator.
package bbi_pkg;

  localparam logic [15:0] START_LIFE_DEF = 16'd700;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 216;

  localparam logic [CFG_IDX_W-1:0] REG_GROUND    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTITUTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_XZ   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 3'd6;

  localparam logic signed [31:0] GROUND_RST    = -32'sd131072;
  localparam logic [15:0]        RESTITUTE_RST = 16'd29491;
  localparam logic [30:0]        THRESHOLD_RST = 31'd19661;
  localparam logic [30:0]        NOISE_RST     = 31'd13107;
  localparam logic [15:0]        FRIC_XZ_RST   = 16'd29491;
  localparam logic [15:0]        FRIC_Y_RST    = 16'd32768;
  localparam logic signed [31:0] GRAVITY_RST   = -32'sd642253;

  localparam logic signed [31:0] PZ_RST = -32'sd393216;

  // Rounding shift applied after a product.
  localparam logic [1:0] SH_15 = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_17 = 2'd2;

  typedef struct packed {
    logic signed [31:0] ground;
    logic [15:0]        restitution;
    logic [30:0]        threshold;
    logic [30:0]        noise;
    logic [15:0]        fric_xz;
    logic [15:0]        fric_y;
    logic signed [31:0] gravity;
  } cfg_t;

  typedef struct packed {
    logic signed [32:0] a;
    logic signed [17:0] b;
    logic [1:0]         sh;
    logic signed [34:0] add;
  } mac_req_t;

  typedef struct packed {
    logic        bounced;
    logic        alive;
    logic [15:0] life_remaining;
    logic [31:0] velocity_z;
    logic [31:0] velocity_y;
    logic [31:0] velocity_x;
    logic [31:0] position_z;
    logic [31:0] position_y;
    logic [31:0] position_x;
  } result_t;

endpackage

// ----- hw/rtl/bouncing_ball_integrator_unit.sv -----
// Top level of the bouncing ball integrator: register file, core and output register.
//
// Each input beat advances one ball by one time step and yields one output beat.
// All products go through one shared multiplier; each multiply is an issue state
// (operands registered) and then a writeback state (round, accumulate and
// saturate). A step without ground contact runs six multiplies; a strong
// bounce adds two, a weak bounce with friction adds four. A new beat is only
// accepted once the core is idle again, after it has handed the result to the
// output register. The output register lets a new beat be accepted while a
// finished result still waits on out_tready. No memory, no clearing pass.
module bouncing_ball_integrator_unit #(
  parameter logic [15:0] START_LIFE = bbi_pkg::START_LIFE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bbi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: time_step[15:0], noise_sign[16], zero fill.
  input  logic [bbi_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: position_x, position_y, position_z, velocity_x,
  // velocity_y, velocity_z (32 bits each), life_remaining (16), alive,
  // bounced, zero fill.
  output logic [bbi_pkg::OUT_DATA_W-1:0]   out_tdata
);

  bbi_pkg::cfg_t    cfg_r;
  bbi_pkg::result_t res;
  bbi_pkg::result_t out_data_r;
  logic             out_valid_r;
  logic             idle;
  logic             res_valid;
  logic             res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ground      <= bbi_pkg::GROUND_RST;
      cfg_r.restitution <= bbi_pkg::RESTITUTE_RST;
      cfg_r.threshold   <= bbi_pkg::THRESHOLD_RST;
      cfg_r.noise       <= bbi_pkg::NOISE_RST;
      cfg_r.fric_xz     <= bbi_pkg::FRIC_XZ_RST;
      cfg_r.fric_y      <= bbi_pkg::FRIC_Y_RST;
      cfg_r.gravity     <= bbi_pkg::GRAVITY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bbi_pkg::REG_GROUND:    cfg_r.ground      <= $signed(cfg_wdata);
        bbi_pkg::REG_RESTITUTE: cfg_r.restitution <= cfg_wdata[15:0];
        bbi_pkg::REG_THRESHOLD: cfg_r.threshold   <= cfg_wdata[30:0];
        bbi_pkg::REG_NOISE:     cfg_r.noise       <= cfg_wdata[30:0];
        bbi_pkg::REG_FRIC_XZ:   cfg_r.fric_xz     <= cfg_wdata[15:0];
        bbi_pkg::REG_FRIC_Y:    cfg_r.fric_y      <= cfg_wdata[15:0];
        bbi_pkg::REG_GRAVITY:   cfg_r.gravity     <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  assign in_tready = idle;
  assign res_ready = !out_valid_r || out_tready;

  bbi_core #(
    .START_LIFE (START_LIFE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .start      (in_tvalid),
    .time_step  (in_tdata[15:0]),
    .noise_sign (in_tdata[16]),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule

// ----- hw/rtl/bbi_mac.sv -----
// Shared multiply, round, accumulate and saturate unit of the integrator.
module bbi_mac (
  input  logic                clk,
  input  bbi_pkg::mac_req_t   req,
  output logic signed [31:0]  res
);

  logic signed [50:0] p_r;
  logic signed [50:0] p_nxt;
  logic [1:0]         sh_r;
  logic signed [34:0] add_r;

  assign p_nxt = req.a * req.b;

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    sh_r  <= req.sh;
    add_r <= req.add;
  end

  logic signed [51:0] p_ext;
  logic signed [51:0] rnd;
  logic signed [52:0] sum;

  always_comb begin
    p_ext = $signed({p_r[50], p_r});
    unique case (sh_r)
      bbi_pkg::SH_15: rnd = (p_ext + 52'sd16384) >>> 15;
      bbi_pkg::SH_16: rnd = (p_ext + 52'sd32768) >>> 16;
      bbi_pkg::SH_17: rnd = (p_ext + 52'sd65536) >>> 17;
      default:        rnd = p_ext;
    endcase
    sum = $signed({rnd[51], rnd}) + $signed({{18{add_r[34]}}, add_r});
    if (sum > 53'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (sum < -53'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = $signed(sum[31:0]);
    end
  end

endmodule

// ----- hw/rtl/bbi_core.sv -----
// Ball state and the sequencer that steps it through the shared unit.
`include "bouncing_ball_integrator_unit_defines.svh"

module bbi_core #(
  parameter logic [15:0] START_LIFE = bbi_pkg::START_LIFE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bbi_pkg::cfg_t     cfg,
  input  logic              start,
  input  logic [15:0]       time_step,
  input  logic              noise_sign,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output bbi_pkg::result_t  res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WB    = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [3:0] OP_BOUNCE = 4'd0;
  localparam logic [3:0] OP_NUDGE  = 4'd1;
  localparam logic [3:0] OP_FRIC_X = 4'd2;
  localparam logic [3:0] OP_FRIC_Y = 4'd3;
  localparam logic [3:0] OP_FRIC_Z = 4'd4;
  localparam logic [3:0] OP_DT2    = 4'd5;
  localparam logic [3:0] OP_HALFG  = 4'd6;
  localparam logic [3:0] OP_PX     = 4'd7;
  localparam logic [3:0] OP_VY     = 4'd8;
  localparam logic [3:0] OP_PY     = 4'd9;
  localparam logic [3:0] OP_PZ     = 4'd10;

  logic [1:0]         state_r, state_nxt;
  logic [3:0]         op_r, op_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic [15:0]        life_r, life_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic               sign_r, sign_nxt;
  logic               hit_r, hit_nxt;
  logic [16:0]        dt2_r, dt2_nxt;
  logic signed [31:0] hg_r, hg_nxt;

  bbi_pkg::mac_req_t  req;
  logic signed [31:0] mac_res;

  logic signed [31:0] py_clamp;
  logic [15:0]        life_dec;
  logic               fast_bounce;
  logic               commit;
  logic               first_op_ok;
  logic               last_wb;

  bbi_mac u_mac (
    .clk (clk),
    .req (req),
    .res (mac_res)
  );

  always_comb begin
    req.a   = $signed({vx_r[31], vx_r});
    req.b   = $signed({2'b00, dt_r});
    req.sh  = bbi_pkg::SH_16;
    req.add = '0;
    unique case (op_r)
      OP_BOUNCE: begin
        req.a  = 33'sd0 - $signed({vy_r[31], vy_r});
        req.b  = $signed({2'b00, cfg.restitution});
        req.sh = bbi_pkg::SH_15;
      end
      OP_NUDGE: begin
        req.b   = 18'sd32768;
        req.sh  = bbi_pkg::SH_15;
        req.add = sign_r ? $signed({4'b0000, cfg.noise})
                         : 35'sd0 - $signed({4'b0000, cfg.noise});
      end
      OP_FRIC_X: begin
        req.b  = $signed({2'b00, cfg.fric_xz});
        req.sh = bbi_pkg::SH_15;
      end
      OP_FRIC_Y: begin
        req.a  = $signed({vy_r[31], vy_r});
        req.b  = $signed({2'b00, cfg.fric_y});
        req.sh = bbi_pkg::SH_15;
      end
      OP_FRIC_Z: begin
        req.a  = $signed({vz_r[31], vz_r});
        req.b  = $signed({2'b00, cfg.fric_xz});
        req.sh = bbi_pkg::SH_15;
      end
      OP_DT2: begin
        req.a = $signed({17'd0, dt_r});
      end
      OP_HALFG: begin
        req.a  = $signed({cfg.gravity[31], cfg.gravity});
        req.b  = $signed({1'b0, dt2_r});
        req.sh = bbi_pkg::SH_17;
      end
      OP_PX: begin
        req.add = $signed({{3{px_r[31]}}, px_r});
      end
      OP_VY: begin
        req.a   = $signed({cfg.gravity[31], cfg.gravity});
        req.add = $signed({{3{vy_r[31]}}, vy_r});
      end
      OP_PY: begin
        req.a   = $signed({vy_r[31], vy_r});
        req.add = $signed({{3{py_r[31]}}, py_r}) + $signed({{3{hg_r[31]}}, hg_r});
      end
      OP_PZ: begin
        req.a   = $signed({vz_r[31], vz_r});
        req.add = $signed({{3{pz_r[31]}}, pz_r});
      end
      default: begin
        req.add = '0;
      end
    endcase
  end

  always_comb begin
    py_clamp    = (py_r < cfg.ground) ? cfg.ground : py_r;
    life_dec    = (life_r != 16'd0) ? life_r - 16'd1 : 16'd0;
    fast_bounce = mac_res > $signed({1'b0, cfg.threshold});

    res.position_x     = px_r;
    res.position_y     = py_clamp;
    res.position_z     = pz_r;
    res.velocity_x     = vx_r;
    res.velocity_y     = vy_r;
    res.velocity_z     = vz_r;
    res.life_remaining = life_dec;
    res.alive          = life_dec != 16'd0;
    res.bounced        = hit_r;

    idle      = state_r == ST_IDLE;
    res_valid = state_r == ST_DONE;

    commit      = res_valid && res_ready;
    first_op_ok = (state_r == ST_ISSUE) && ((op_r == OP_BOUNCE) == hit_r);
    last_wb     = (state_r == ST_WB) && (op_r == OP_PZ);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    pz_nxt    = pz_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    vz_nxt    = vz_r;
    life_nxt  = life_r;
    dt_nxt    = dt_r;
    sign_nxt  = sign_r;
    hit_nxt   = hit_r;
    dt2_nxt   = dt2_r;
    hg_nxt    = hg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          dt_nxt    = time_step;
          sign_nxt  = noise_sign;
          hit_nxt   = py_r <= cfg.ground;
          op_nxt    = (py_r <= cfg.ground) ? OP_BOUNCE : OP_DT2;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        state_nxt = ST_ISSUE;
        unique case (op_r)
          OP_BOUNCE: begin
            vy_nxt = mac_res;
            op_nxt = fast_bounce ? OP_NUDGE : OP_FRIC_X;
          end
          OP_NUDGE: begin
            vx_nxt = mac_res;
            op_nxt = OP_DT2;
          end
          OP_FRIC_X: begin
            vx_nxt = mac_res;
            op_nxt = OP_FRIC_Y;
          end
          OP_FRIC_Y: begin
            vy_nxt = mac_res;
            op_nxt = OP_FRIC_Z;
          end
          OP_FRIC_Z: begin
            vz_nxt = mac_res;
            op_nxt = OP_DT2;
          end
          OP_DT2: begin
            dt2_nxt = mac_res[16:0];
            op_nxt  = OP_HALFG;
          end
          OP_HALFG: begin
            hg_nxt = mac_res;
            op_nxt = OP_PX;
          end
          OP_PX: begin
            px_nxt = mac_res;
            op_nxt = OP_VY;
          end
          OP_VY: begin
            vy_nxt = mac_res;
            op_nxt = OP_PY;
          end
          OP_PY: begin
            py_nxt = mac_res;
            op_nxt = OP_PZ;
          end
          OP_PZ: begin
            pz_nxt    = mac_res;
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (res_ready) begin
          py_nxt    = py_clamp;
          life_nxt  = life_dec;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_DT2;
      px_r    <= '0;
      py_r    <= '0;
      pz_r    <= bbi_pkg::PZ_RST;
      vx_r    <= '0;
      vy_r    <= '0;
      vz_r    <= '0;
      life_r  <= START_LIFE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      vx_r    <= vx_nxt;
      vy_r    <= vy_nxt;
      vz_r    <= vz_nxt;
      life_r  <= life_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    sign_r <= sign_nxt;
    hit_r  <= hit_nxt;
    dt2_r  <= dt2_nxt;
    hg_r   <= hg_nxt;
  end

  `BBI_ASSERT_NEXT(a_start_op, clk, rst_n, start && idle, first_op_ok, "wrong first operation")
  `BBI_ASSERT_NEXT(a_pz_last, clk, rst_n, last_wb, res_valid, "no result after z position")
  `BBI_ASSERT_NEXT(a_life_dec, clk, rst_n, commit, life_r == $past(life_dec), "bad lifetime")
  `BBI_ASSERT_NEXT(a_floor, clk, rst_n, commit, py_r >= $past(cfg.ground), "height below ground")
  `BBI_ASSERT_SAME(a_no_res_idle, clk, rst_n, idle, !res_valid, "result offered while idle")

endmodule
